FILE: rtl/mcod_pkg.sv
// Shared types and constants for the matrix chain order block.
package mcod_pkg;

    localparam int MAX_MATRICES_DEF = 8;
    localparam int IDX_W = 4;
    localparam int COST_W = 63;
    localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

    typedef struct packed {
        logic [15:0] dimension;
        logic        final_dimension;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  first_matrix;
        logic [IDX_W-1:0]  final_matrix;
        logic [COST_W-1:0] min_cost;
        logic [IDX_W-1:0]  best_split;
        logic              chain_error;
        logic              final_result;
    } out_item_t;

    // Job handed from the loader to the solver.
    typedef struct packed {
        logic             bad;
        logic [IDX_W-1:0] n;
    } job_t;

endpackage

FILE: rtl/mcod_front.sv
// Loader: stores dimensions, classifies the chain, hands a job to the solver.
module mcod_front #(
    parameter int MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mcod_pkg::in_item_t in_item,
    input  logic               in_valid,
    output logic               in_ready,
    output mcod_pkg::job_t     job,
    output logic               job_valid,
    input  logic               job_ready,
    output logic [15:0]        dims [MAX_MATRICES+1]
);
    import mcod_pkg::*;

    localparam int DEPTH = MAX_MATRICES + 1;

    logic [IDX_W-1:0] count_reg;
    logic             over_reg;
    logic             job_valid_reg;
    job_t             job_reg;
    logic [15:0]      dim_reg [DEPTH];
    logic             take;

    // Stall loading while a job waits: the solver reads the store directly.
    assign in_ready  = !job_valid_reg && job_ready;
    assign take      = in_valid && in_ready;
    assign job       = job_reg;
    assign job_valid = job_valid_reg;
    assign dims      = dim_reg;

    always_ff @(posedge clk)
    begin
        if (take && count_reg < IDX_W'(DEPTH))
        begin
            dim_reg[count_reg] <= in_item.dimension;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            over_reg      <= 1'b0;
            job_valid_reg <= 1'b0;
            job_reg       <= '0;
        end
        else
        begin
            if (job_valid_reg)
            begin
                job_valid_reg <= 1'b0;
            end
            if (take)
            begin
                logic [IDX_W-1:0] cnt_next;
                logic             over_next;
                cnt_next  = count_reg;
                over_next = over_reg;
                if (count_reg < IDX_W'(DEPTH))
                begin
                    cnt_next = count_reg + 1'b1;
                end
                else
                begin
                    over_next = 1'b1;
                end
                if (in_item.final_dimension)
                begin
                    job_reg.bad   <= over_next || cnt_next < IDX_W'(2);
                    job_reg.n     <= cnt_next - 1'b1;
                    job_valid_reg <= 1'b1;
                    count_reg     <= '0;
                    over_reg      <= 1'b0;
                end
                else
                begin
                    count_reg <= cnt_next;
                    over_reg  <= over_next;
                end
            end
        end
    end

endmodule

FILE: rtl/mcod_solver.sv
// Solver: fills cost and split tables by chain length, then emits results.
module mcod_solver #(
    parameter int MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mcod_pkg::job_t      job,
    input  logic                job_valid,
    output logic                job_ready,
    input  logic [15:0]         dims [MAX_MATRICES+1],
    output mcod_pkg::out_item_t out_item,
    output logic                out_valid,
    input  logic                out_ready
);
    import mcod_pkg::*;

    localparam int SIDE  = MAX_MATRICES + 1;
    localparam int TAB_D = SIDE * SIDE;
    localparam int TAB_W = $clog2(TAB_D);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_RD, S_MUL1, S_ADD, S_CMP, S_WR,
        S_ERR, S_ERD, S_EWAIT, S_EOUT
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] n_reg, len_reg, i_reg, k_reg, j_reg;
    logic [COST_W-1:0] best_reg, lhs_reg, rhs_reg, prod_reg, q_reg;
    logic [IDX_W-1:0] bestk_reg;
    logic             have_reg;
    logic [31:0]      p1_reg;
    logic [15:0]      dj_reg;
    out_item_t        out_reg;
    logic             out_valid_reg;

    // Tables: two read ports, one write port.
    logic [COST_W-1:0] cost_mem [TAB_D];
    logic [IDX_W-1:0]  split_mem [TAB_D];
    logic [TAB_W-1:0]  ra_a, ra_b, wa;
    logic              we;
    logic [COST_W-1:0] wd_cost, rd_a, rd_b;
    logic [IDX_W-1:0]  wd_split, rd_split;

    function automatic logic [TAB_W-1:0] tix(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
        tix = TAB_W'(r * SIDE + c);
    endfunction

    function automatic logic [COST_W-1:0] sadd(input logic [COST_W-1:0] a,
                                               input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        sadd = s[COST_W] ? COST_SAT : s[COST_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cost_mem[wa]  <= wd_cost;
            split_mem[wa] <= wd_split;
        end
        rd_a     <= cost_mem[ra_a];
        rd_b     <= cost_mem[ra_b];
        rd_split <= split_mem[ra_a];
    end

    always_comb
    begin
        ra_a     = tix(i_reg, k_reg);
        ra_b     = tix(k_reg + 1'b1, j_reg);
        if (state_reg == S_ERD || state_reg == S_EWAIT || state_reg == S_EOUT)
        begin
            ra_a = tix(i_reg, j_reg);
        end
        we       = 1'b0;
        wa       = tix(i_reg, j_reg);
        wd_cost  = best_reg;
        wd_split = bestk_reg;
        if (state_reg == S_INIT)
        begin
            we       = 1'b1;
            wa       = tix(i_reg, i_reg);
            wd_cost  = '0;
            wd_split = '0;
        end
        else if (state_reg == S_WR)
        begin
            we = 1'b1;
        end
    end

    assign job_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_item  = out_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            n_reg <= '0; len_reg <= '0; i_reg <= '0; k_reg <= '0; j_reg <= '0;
            have_reg <= 1'b0;
        end
        else
        begin
            // S_EOUT handles its own drain and reload of the output beat.
            if (out_valid_reg && out_ready && state_reg != S_EOUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && job_ready)
                    begin
                        n_reg <= job.n;
                        i_reg <= IDX_W'(1);
                        if (job.bad)
                        begin
                            state_reg <= S_ERR;
                        end
                        else
                        begin
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    if (i_reg == n_reg)
                    begin
                        if (n_reg == IDX_W'(1))
                        begin
                            out_reg <= '{first_matrix: IDX_W'(1),
                                         final_matrix: IDX_W'(1),
                                         min_cost: '0, best_split: '0,
                                         chain_error: 1'b0, final_result: 1'b1};
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            len_reg   <= IDX_W'(2);
                            i_reg     <= IDX_W'(1);
                            j_reg     <= IDX_W'(2);
                            k_reg     <= IDX_W'(1);
                            have_reg  <= 1'b0;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_RD:
                begin
                    dj_reg    <= dims[j_reg];
                    p1_reg    <= 32'(dims[i_reg - 1'b1]) * 32'(dims[k_reg]);
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    lhs_reg   <= rd_a;
                    rhs_reg   <= rd_b;
                    prod_reg  <= COST_W'(48'(p1_reg) * 48'(dj_reg));
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    q_reg     <= sadd(sadd(lhs_reg, rhs_reg), prod_reg);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (!have_reg || q_reg < best_reg)
                    begin
                        best_reg  <= q_reg;
                        bestk_reg <= k_reg;
                    end
                    have_reg <= 1'b1;
                    if (k_reg + 1'b1 == j_reg)
                    begin
                        state_reg <= S_WR;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_WR:
                begin
                    have_reg <= 1'b0;
                    if (j_reg == n_reg)
                    begin
                        if (len_reg == n_reg)
                        begin
                            i_reg     <= IDX_W'(1);
                            j_reg     <= IDX_W'(2);
                            state_reg <= S_ERD;
                        end
                        else
                        begin
                            len_reg   <= len_reg + 1'b1;
                            i_reg     <= IDX_W'(1);
                            j_reg     <= len_reg + 1'b1;
                            k_reg     <= IDX_W'(1);
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= j_reg + 1'b1;
                        k_reg     <= i_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_ERR:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg <= '{first_matrix: '0, final_matrix: '0,
                                     min_cost: '0, best_split: '0,
                                     chain_error: 1'b1, final_result: 1'b1};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_ERD:
                begin
                    // address is presented now; data arrives next cycle
                    state_reg <= S_EWAIT;
                end
                S_EWAIT:
                begin
                    state_reg <= S_EOUT;
                end
                S_EOUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg <= '{first_matrix: i_reg, final_matrix: j_reg,
                                     min_cost: rd_a, best_split: rd_split,
                                     chain_error: 1'b0,
                                     final_result: (i_reg == n_reg - 1'b1)
                                                   && (j_reg == n_reg)};
                        out_valid_reg <= 1'b1;
                        if (j_reg == n_reg)
                        begin
                            if (i_reg == n_reg - 1'b1)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                i_reg     <= i_reg + 1'b1;
                                j_reg     <= i_reg + 2'd2;
                                state_reg <= S_ERD;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_ERD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/matrix_chain_order_dp_top.sv
// Matrix chain ordering engine: top level joining loader and solver.
// Usage:
//   Input channel carries one dimension per beat; the beat with
//   final_dimension high closes the chain and starts the solve.
//   Output channel carries one result per subchain i<j in row-major order;
//   final_result marks the last beat of the chain. An invalid count gives
//   one beat with chain_error high; a single matrix gives one zero-cost beat.
// Sequence:
//   A dimension is accepted only while no job waits and the solver is idle
//   with no result held; the final beat registers a job for the solver.
//   The solve first clears the diagonal, then evaluates each split by read,
//   multiply, add and compare steps, and writes each subchain's best cost
//   and split; each result is then addressed, read and emitted in turn.
//   Loading of the next chain waits until the solver is idle again.
// Reset:
//   rst_n clears load counters, the job handshake and the output valid.
// Stall:
//   A held output beat stops emission; results are never dropped.
module matrix_chain_order_dp_top #(
    parameter int MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mcod_pkg::in_item_t  in_item,
    input  logic                in_valid,
    output logic                in_ready,
    output mcod_pkg::out_item_t out_item,
    output logic                out_valid,
    input  logic                out_ready
);
    import mcod_pkg::*;

    job_t        job;
    logic        job_valid, job_ready;
    logic [15:0] dims [MAX_MATRICES+1];

    mcod_front #(.MAX_MATRICES(MAX_MATRICES)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_item), .in_valid(in_valid), .in_ready(in_ready),
        .job(job), .job_valid(job_valid), .job_ready(job_ready),
        .dims(dims)
    );

    mcod_solver #(.MAX_MATRICES(MAX_MATRICES)) u_solver (
        .clk(clk), .rst_n(rst_n),
        .job(job), .job_valid(job_valid), .job_ready(job_ready),
        .dims(dims),
        .out_item(out_item), .out_valid(out_valid), .out_ready(out_ready)
    );

endmodule

FILE: test/matrix_chain_order_dp_checker.sv
// Checker for the matrix chain order block: predicts subchain costs and compares result beats.
module matrix_chain_order_dp_checker #(
    parameter int MAX_MATRICES = mcod_pkg::MAX_MATRICES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mcod_pkg::in_item_t  in_item,
    input  logic                in_valid,
    input  logic                in_ready,
    input  mcod_pkg::out_item_t out_item,
    input  logic                out_valid,
    input  logic                out_ready,
    output int                  fail_count,
    output int                  pending_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import mcod_pkg::*;

    localparam int SIDE = MAX_MATRICES + 1;

    logic [15:0]       dims [SIDE];
    int                dim_count;
    logic              overflowed;
    out_item_t         expected_results [$];

    function automatic logic [COST_W-1:0] sat_sum(logic [COST_W-1:0] a,
                                                  logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_SAT : s[COST_W-1:0];
    endfunction

    // Fill cost and split tables by chain length and queue the results.
    task automatic solve_chain(int n);
        logic [COST_W-1:0] cost [SIDE][SIDE];
        logic [IDX_W-1:0]  split [SIDE][SIDE];
        logic [COST_W-1:0] q;
        logic [COST_W-1:0] best;
        logic [47:0]       prod;
        out_item_t         r;
        int                j;
        for (int i = 1; i <= n; i++)
        begin
            cost[i][i] = '0;
            split[i][i] = '0;
        end
        for (int len = 2; len <= n; len++)
        begin
            for (int i = 1; i + len - 1 <= n; i++)
            begin
                j = i + len - 1;
                best = '0;
                for (int k = i; k < j; k++)
                begin
                    prod = 48'(dims[i-1]) * 48'(dims[k]) * 48'(dims[j]);
                    q = sat_sum(sat_sum(cost[i][k], cost[k+1][j]), COST_W'(prod));
                    if (k == i || q < best)
                    begin
                        best = q;
                        split[i][j] = IDX_W'(k);
                    end
                end
                cost[i][j] = best;
            end
        end
        if (n == 1)
        begin
            r = '0;
            r.first_matrix = IDX_W'(1);
            r.final_matrix = IDX_W'(1);
            r.final_result = 1'b1;
            expected_results.push_back(r);
        end
        else
        begin
            for (int i = 1; i <= n; i++)
            begin
                for (int jj = i + 1; jj <= n; jj++)
                begin
                    r = '0;
                    r.first_matrix = IDX_W'(i);
                    r.final_matrix = IDX_W'(jj);
                    r.min_cost = cost[i][jj];
                    r.best_split = split[i][jj];
                    r.final_result = (i == n - 1) && (jj == n);
                    expected_results.push_back(r);
                end
            end
        end
    endtask

    task automatic check_field(string name, logic [COST_W-1:0] exp_v,
                               logic [COST_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    assign pending_results = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t         e;
        out_item_t         r;
        if (!rst_n)
        begin
            dim_count <= 0;
            overflowed <= 1'b0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (dim_count < SIDE) dims[dim_count] = in_item.dimension;
                if (in_item.final_dimension)
                begin
                    if (overflowed || dim_count >= SIDE || dim_count + 1 < 2)
                    begin
                        r = '0;
                        r.chain_error = 1'b1;
                        r.final_result = 1'b1;
                        expected_results.push_back(r);
                    end
                    else
                    begin
                        solve_chain(dim_count);
                    end
                    dim_count <= 0;
                    overflowed <= 1'b0;
                end
                else if (dim_count < SIDE)
                begin
                    dim_count <= dim_count + 1;
                end
                else
                begin
                    overflowed <= 1'b1;
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result beat");
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("first_matrix", COST_W'(e.first_matrix),
                                COST_W'(out_item.first_matrix));
                    check_field("final_matrix", COST_W'(e.final_matrix),
                                COST_W'(out_item.final_matrix));
                    check_field("min_cost", e.min_cost, out_item.min_cost);
                    check_field("best_split", COST_W'(e.best_split),
                                COST_W'(out_item.best_split));
                    check_field("chain_error", COST_W'(e.chain_error),
                                COST_W'(out_item.chain_error));
                    check_field("final_result", COST_W'(e.final_result),
                                COST_W'(out_item.final_result));
                end
            end
        end
    end
endmodule

FILE: test/matrix_chain_order_dp_top_tb.sv
// Testbench top for the matrix chain order block: stimulus, idling and verdict.
module matrix_chain_order_dp_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mcod_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    in_item_t  in_item;
    logic      in_valid;
    logic      in_ready;
    out_item_t out_item;
    logic      out_valid;
    logic      out_ready;
    int        fail_count;
    int        pending_results;
    int        sender_idle_pct;
    int        receiver_idle_pct;
    int        idle_cycles;
    int        items_sent;

    matrix_chain_order_dp_top u_dut (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .in_valid(in_valid),
        .in_ready(in_ready), .out_item(out_item), .out_valid(out_valid),
        .out_ready(out_ready)
    );

    matrix_chain_order_dp_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .in_valid(in_valid),
        .in_ready(in_ready), .out_item(out_item), .out_valid(out_valid),
        .out_ready(out_ready), .fail_count(fail_count),
        .pending_results(pending_results)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Count cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive one beat, with a random gap before it; hold until accepted.
    task automatic send_dim(logic [15:0] dim, logic fin);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item <= '{dimension: dim, final_dimension: fin};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    function automatic logic [15:0] random_dim();
        case ($urandom_range(5))
            0: return 16'hFFFF;
            1: return 16'($urandom_range(1));
            2: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic send_chain(int count, bit big);
        for (int d = 0; d < count; d++)
        begin
            send_dim(big ? 16'hFFFF - 16'($urandom_range(1)) : random_dim(),
                     d == count - 1);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        out_ready <= 1'b0;
        items_sent = 0;
        sender_idle_pct = 25;
        receiver_idle_pct = 88;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: error on one entry, single matrix, full chain, overflow,
        // max dimensions, zero dimensions.
        send_dim(16'd7, 1'b1);
        send_chain(2, 1'b0);
        send_dim(16'd0, 1'b0);
        send_dim(16'd5, 1'b0);
        send_dim(16'd0, 1'b1);
        for (int d = 0; d < 9; d++) send_dim(16'hFFFF, d == 8);
        send_chain(9, 1'b0);
        send_chain(11, 1'b0);
        send_chain(4, 1'b0);

        while (items_sent < 270)
        begin
            if (items_sent > 90 && items_sent < 180)
            begin
                sender_idle_pct = 88;
                receiver_idle_pct = 25;
            end
            else if (items_sent >= 180)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            case ($urandom_range(9))
                0: send_chain($urandom_range(10, 12), 1'b0);
                1: send_chain(1, 1'b0);
                2: send_chain(9, 1'b1);
                default: send_chain($urandom_range(2, 9), 1'b0);
            endcase
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (800) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
